### src/bf3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 box mean filter.
// Used by box_filter_3x3_top; depends on nothing else.
package bf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Address width of one line store.
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    // Width of the configuration registers and of the clamped sizes.
    localparam int CFG_W  = 11;
    // Width of the register index on the configuration port.
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] SIZE_MIN  = 11'd3;
    localparam logic [CFG_W-1:0] WIDTH_HI  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_HI = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] SIZE_RST  = 11'd1024;

    // ceil(2^16 / 9): (x * RECIP_9) >> 16 equals x / 9 for every x below 32768.
    localparam logic [12:0] RECIP_9 = 13'd7282;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } t_in_req;

    typedef struct packed {
        logic [7:0] mean_value;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       frame_last;
    } t_out_req;

endpackage

### src/box_filter_3x3_top.sv
`timescale 1ns / 1ps
// 3x3 box mean filter: line stores, sliding window, rounded divide by nine.
// Depends on bf3_pkg for the request types and constants.

// The block takes one grayscale pixel request per clock while not stalled,
// in raster order, and returns, for each interior pixel, the rounded mean
// (sum + 4) / 9 of its 3x3 neighborhood together with the row and column of
// that center pixel; border pixels produce no result. A pixel with frame_start
// set restarts the position at row 0, column 0, and it also wraps by itself
// after the last pixel of a frame. Frame width and height are set through the
// write port (index 0 and 1) and are clamped to 3..1024 when used; write them
// only while the block is idle. The sustained rate is one pixel per clock when
// not stalled: the two line stores have a registered read, each read once at
// the pixel's column when the request is accepted and written back once when
// that pixel leaves stage 1, so every memory port is used once per pixel. A
// result passes the registered memory read, window update, and sum and divide
// before it leaves the output register. The whole pipeline advances only when
// the output register is free or is being taken, so o_in_stall simply mirrors
// a held output. The line stores are not cleared after reset and need no
// clearing pass; a frame fills them before any entry is read for a result.
module box_filter_3x3_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Pixel requests in.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  bf3_pkg::t_in_req        i_in_req,
    // Filtered results out.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output bf3_pkg::t_out_req       o_out_req,
    // Configuration writes.
    input  logic                    i_cfg_we,
    input  logic [bf3_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [bf3_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int AW = bf3_pkg::ADDR_W;
    localparam int CW = bf3_pkg::CFG_W;

    // Configuration registers.
    logic [CW-1:0] r_frame_width;
    logic [CW-1:0] r_frame_height;

    // Position of the next pixel.
    logic [9:0] r_row;
    logic [9:0] r_col;

    // Line stores.
    logic [7:0] r_mem_up  [bf3_pkg::MAX_WIDTH];
    logic [7:0] r_mem_mid [bf3_pkg::MAX_WIDTH];

    // Stage 1: the accepted pixel, waiting for its line store data.
    logic          r_s1_valid;
    logic [9:0]    r_s1_row;
    logic [9:0]    r_s1_col;
    logic [7:0]    r_s1_pix;
    logic          r_s1_last;
    logic [7:0]    r_rd_up;
    logic [7:0]    r_rd_mid;
    logic          r_fwd;
    logic [7:0]    r_fwd_up;
    logic [7:0]    r_fwd_mid;

    // Window, indexed [row][column], column 2 being the newest.
    logic [7:0]    r_win [3][3];

    // Stage 2: the window holds a complete neighborhood to be averaged.
    logic          r_s2_valid;
    logic [9:0]    r_s2_row;
    logic [9:0]    r_s2_col;
    logic          r_s2_last;

    // Output register.
    logic              r_out_valid;
    bf3_pkg::t_out_req r_out_req;

    logic          w_en;
    logic          w_accept;
    logic [CW-1:0] w_w;
    logic [CW-1:0] w_h;
    logic [CW-1:0] w_c0;
    logic [CW-1:0] w_r0;
    logic [CW-1:0] w_r1;
    logic [9:0]    w_c;
    logic [9:0]    w_r;
    logic          w_col_end;
    logic          w_row_end;
    logic [9:0]    n_row;
    logic [9:0]    n_col;
    logic [7:0]    w_up_eff;
    logic [7:0]    w_mid_eff;
    logic [11:0]   w_sum;
    logic [24:0]   w_prod;

    // The pipeline moves whenever the output register can take a new value.
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    // Clamp the sizes to 3..max.
    always_comb begin
        if (r_frame_width < bf3_pkg::SIZE_MIN) begin
            w_w = bf3_pkg::SIZE_MIN;
        end else if (r_frame_width > bf3_pkg::WIDTH_HI) begin
            w_w = bf3_pkg::WIDTH_HI;
        end else begin
            w_w = r_frame_width;
        end
        if (r_frame_height < bf3_pkg::SIZE_MIN) begin
            w_h = bf3_pkg::SIZE_MIN;
        end else if (r_frame_height > bf3_pkg::HEIGHT_HI) begin
            w_h = bf3_pkg::HEIGHT_HI;
        end else begin
            w_h = r_frame_height;
        end
    end

    // Position of the incoming pixel. A frame start restarts at the origin;
    // a stored position beyond a shrunken frame wraps to the next row or to
    // the top of a new frame.
    always_comb begin
        w_c0 = i_in_req.frame_start ? '0 : {1'b0, r_col};
        w_r0 = i_in_req.frame_start ? '0 : {1'b0, r_row};
        if (w_c0 >= w_w) begin
            w_c0 = '0;
            w_r0 = w_r0 + 1'b1;
        end
        w_r1 = (w_r0 >= w_h) ? '0 : w_r0;
        w_c  = w_c0[9:0];
        w_r  = w_r1[9:0];
        w_col_end = ({1'b0, w_c} + 1'b1) >= w_w;
        w_row_end = ({1'b0, w_r} + 1'b1) >= w_h;
        if (w_col_end) begin
            n_col = '0;
            n_row = w_row_end ? '0 : w_r + 1'b1;
        end else begin
            n_col = w_c + 1'b1;
            n_row = w_r;
        end
    end

    // Line store data for the pixel in stage 1. When the pixel just before it
    // wrote the same column in the cycle of the read, the memory returned the
    // old entry, so the forwarded copy is used instead.
    assign w_up_eff  = r_fwd ? r_fwd_up  : r_rd_up;
    assign w_mid_eff = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bf3_pkg::SIZE_RST;
            r_frame_height <= bf3_pkg::SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bf3_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bf3_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Memory read at the accepted pixel's column.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_up  <= r_mem_up[w_c[AW-1:0]];
            r_rd_mid <= r_mem_mid[w_c[AW-1:0]];
        end
    end

    // Write-back: the middle row moves up and the new pixel becomes the middle.
    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            r_mem_up[r_s1_col[AW-1:0]]  <= w_mid_eff;
            r_mem_mid[r_s1_col[AW-1:0]] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            r_fwd      <= w_accept && r_s1_valid && (r_s1_col == w_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row  <= w_r;
            r_s1_col  <= w_c;
            r_s1_pix  <= i_in_req.pixel_value;
            r_s1_last <= ({1'b0, w_r} == w_h - 1'b1) && ({1'b0, w_c} == w_w - 1'b1);
            r_fwd_up  <= w_mid_eff;
            r_fwd_mid <= r_s1_pix;
        end
    end

    // Window shift and stage 2 hand-over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            if (r_s1_valid) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= w_up_eff;
                r_win[1][2] <= w_mid_eff;
                r_win[2][2] <= r_s1_pix;
            end
            r_s2_valid <= r_s1_valid && (r_s1_row >= 10'd2) && (r_s1_col >= 10'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            r_s2_row  <= r_s1_row - 1'b1;
            r_s2_col  <= r_s1_col - 1'b1;
            r_s2_last <= r_s1_last;
        end
    end

    // Sum of the nine pixels plus the rounding offset, then divide by nine
    // through the reciprocal.
    always_comb begin
        w_sum = 12'd4;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_sum = w_sum + {4'd0, r_win[k][j]};
            end
        end
        w_prod = {13'd0, w_sum} * {12'd0, bf3_pkg::RECIP_9};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s2_valid) begin
            r_out_req.mean_value <= w_prod[23:16];
            r_out_req.out_row    <= r_s2_row;
            r_out_req.out_col    <= r_s2_col;
            r_out_req.frame_last <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // The input is held off only by a result that waits downstream.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // Every result sits around a center off the top row and the left column.
    a_interior : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.out_row != 10'd0) && (o_out_req.out_col != 10'd0))
        else $error("result for a border pixel");

    // A same-column forward only follows an accepted pixel in stage 1.
    a_fwd_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward without a pixel in stage 1");

    // Reset leaves no result behind.
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

### sim/box_filter_3x3_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_filter_3x3_top: pixel frames go in, 3x3 means come out.
// Depends on bf3_pkg for the request types, register indexes and size limits.
module box_filter_3x3_top_test;

    localparam int CW = bf3_pkg::CFG_W;
    localparam int IW = bf3_pkg::CIDX_W;

    // Unused indexes on the configuration port. Writes to them must change nothing.
    localparam logic [IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] CFG_SPARE_B = 2'd3;

    // Pixels that produce no result still have to clear the pipeline after the
    // last owed mean; this drain time allows for that.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1400;
    // The last stretch of the random stream runs with no idling on either side.
    localparam int QUIET_FROM   = 950;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    bf3_pkg::t_in_req     i_in_req    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    bf3_pkg::t_out_req    o_out_req;
    logic                 i_cfg_we    = 1'b0;
    logic [IW-1:0]        i_cfg_index = '0;
    logic [CW-1:0]        i_cfg_data  = '0;

    box_filter_3x3_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the filter state. The line stores start at zero here; the
    // stimulus never lets an entry that the block has not written reach a result.
    logic [7:0]       upper_line  [bf3_pkg::MAX_WIDTH];
    logic [7:0]       middle_line [bf3_pkg::MAX_WIDTH];
    logic [7:0]       win [3][3];
    int unsigned      pos_row = 0;
    int unsigned      pos_col = 0;
    logic [CW-1:0]    width_reg  = bf3_pkg::SIZE_RST;
    logic [CW-1:0]    height_reg = bf3_pkg::SIZE_RST;

    // Means that the block still owes, oldest first.
    bf3_pkg::t_out_req expected_means[$];

    int unsigned      err_count   = 0;
    int unsigned      cycle_count = 0;
    int unsigned      random_sent = 0;
    // When cleared, the sender never pauses and the receiver never stalls.
    bit               idle_on     = 1'b1;

    initial begin
        for (int i = 0; i < bf3_pkg::MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                win[k][j] = '0;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The run is bounded: a hang or a missing result ends it here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("box_filter_3x3_top_test: errors");
            $finish;
        end
    end

    // The receiver stalls at random, with a chance of 9 in 100, while idling is on.
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 9);
    end

    // Sizes are clamped to 3..limit at the moment they are used.
    function automatic int unsigned clamp_dim(input logic [CW-1:0] v,
                                              input int unsigned hi);
        if (v < bf3_pkg::SIZE_MIN) return bf3_pkg::SIZE_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow filter by one accepted pixel and queue the mean that it
    // completes, if any. Only interior pixels get a result, and the result names
    // the center of the window, one row and one column behind the new pixel.
    task automatic model_pixel(input bf3_pkg::t_in_req req);
        int unsigned       w, h, r, c, sum;
        bf3_pkg::t_out_req res;
        w = clamp_dim(width_reg, bf3_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, bf3_pkg::MAX_HEIGHT);
        if (req.frame_start) begin
            pos_row = 0;
            pos_col = 0;
        end
        // A position left past the size by a register change folds back here.
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        r = pos_row;
        c = pos_col;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = req.pixel_value;
        upper_line[c]  = middle_line[c];
        middle_line[c] = req.pixel_value;

        if (r >= 2 && c >= 2) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    sum += win[k][j];
                end
            end
            res.mean_value = 8'((sum + 4) / 9);
            res.out_row    = 10'(r - 1);
            res.out_col    = 10'(c - 1);
            res.frame_last = (r == h - 1) && (c == w - 1);
            expected_means.push_back(res);
        end

        // The position wraps by itself after the last pixel of a frame.
        if (c + 1 >= w) begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endtask

    // Present one pixel request and hold it until the block takes it. Valid is
    // left high after acceptance so that back-to-back requests need no gap.
    task automatic send_pixel(input logic [7:0] pix, input logic start);
        bf3_pkg::t_in_req req;
        req.pixel_value = pix;
        req.frame_start = start;
        while (idle_on && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_pixel(req);
    endtask

    // Stop sending, wait for every owed mean, then let the pipeline run dry.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write, after which the enable goes low again.
    task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bf3_pkg::CFG_FRAME_WIDTH) width_reg = value;
        else if (idx == bf3_pkg::CFG_FRAME_HEIGHT) height_reg = value;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Every result taken from the block is compared with the oldest owed mean.
    always @(posedge i_clk) begin : check_results
        bf3_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_means.size() == 0) begin
                err_count++;
                $display("%0t: result with no pixel owed: expected none, actual %0d/%0d/%0d/%0b",
                         $time, o_out_req.mean_value, o_out_req.out_row,
                         o_out_req.out_col, o_out_req.frame_last);
            end else begin
                want = expected_means.pop_front();
                check_field("mean_value", want.mean_value, o_out_req.mean_value);
                check_field("out_row", want.out_row, o_out_req.out_row);
                check_field("out_col", want.out_col, o_out_req.out_col);
                check_field("frame_last", want.frame_last, o_out_req.frame_last);
            end
        end
    end

    // Default 1024 x 1024 frame: the first pixels of row 0 fill the stores and give nothing.
    task automatic test_after_reset();
        for (int i = 0; i < 6; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
    endtask

    // Sizes below the minimum clamp to a 3 x 3 frame with a single result. A
    // frame of full-scale pixels gives the top mean, and the next frame, which
    // begins by wrapping rather than by a frame start, gives zero.
    task automatic test_tiny_frames();
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'd0);
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd2);
        for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
        for (int i = 0; i < 9; i++) send_pixel(8'h00, 1'b0);
        wait_idle();
    endtask

    // Writes to unused indexes must leave the 3 x 3 setting in place.
    task automatic test_unknown_index();
        write_reg(CFG_SPARE_A, 11'h7FF);
        write_reg(CFG_SPARE_B, 11'h000);
        for (int i = 0; i < 9; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
    endtask

    // A frame start in the middle of a frame puts the position back at the origin.
    task automatic test_restart_mid_frame();
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'd5);
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd4);
        for (int i = 0; i < 7; i++) send_pixel(8'($urandom), i == 0);
        for (int i = 0; i < 20; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
    endtask

    // Shrinking the sizes in mid frame leaves the position past them.
    task automatic test_size_shrink();
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'd8);
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd8);
        for (int i = 0; i < 30; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
        // Column 6 is past the new width, so the next pixel opens row 4.
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'd4);
        for (int i = 0; i < 9; i++) send_pixel(8'($urandom), 1'b0);
        wait_idle();
        // Row 6 is past the new height, so the next pixel lands in row 0.
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd3);
        for (int i = 0; i < 12; i++) send_pixel(8'($urandom), 1'b0);
        wait_idle();
    endtask

    // An oversized width clamps to 1024, so the start of the first row runs on
    // with no result and no early wrap.
    task automatic test_wide_frame();
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'h7FF);
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd1);
        for (int i = 0; i < 64; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
    endtask

    // Tall frame: three columns of a 1024-row frame, the first hundred rows.
    task automatic test_tall_frame();
        write_reg(bf3_pkg::CFG_FRAME_WIDTH, 11'd3);
        write_reg(bf3_pkg::CFG_FRAME_HEIGHT, 11'd1024);
        for (int i = 0; i < 3 * 100; i++) send_pixel(8'($urandom), i == 0);
        wait_idle();
    endtask

    // Mostly small sizes, now and then out of range or at the top.
    function automatic logic [CW-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return CW'($urandom_range(10, 3));
        if (roll < 88) return CW'($urandom_range(40, 11));
        if (roll < 94) return CW'($urandom_range(2, 0));
        if (roll < 97) return CW'(bf3_pkg::MAX_WIDTH);
        return CW'($urandom_range(2047, 1025));
    endfunction

    // Phases of random frames. Each phase starts with a frame start so that a
    // wider frame never uses a store column it has not filled. Inside a phase,
    // frames follow one another either by wrapping or by a fresh frame start,
    // and now and then a frame start cuts a frame short. A phase that would run
    // past 300 pixels is cut to between 40 and 300.
    task automatic test_random_stream();
        logic [CW-1:0] w_val, h_val;
        int unsigned   roll, frame_len, budget, shade;
        logic [7:0]    pix;
        logic          restart;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= QUIET_FROM) idle_on = 1'b0;
            w_val = pick_size();
            h_val = pick_size();
            roll  = $urandom_range(99);
            if (roll >= 10) write_reg(bf3_pkg::CFG_FRAME_WIDTH, w_val);
            if (roll < 10 || roll >= 20) write_reg(bf3_pkg::CFG_FRAME_HEIGHT, h_val);
            frame_len = clamp_dim(width_reg, bf3_pkg::MAX_WIDTH) *
                        clamp_dim(height_reg, bf3_pkg::MAX_HEIGHT);
            budget    = frame_len * $urandom_range(3, 1);
            if (budget > 300) budget = $urandom_range(300, 40);
            if (budget > RANDOM_ITEMS - random_sent) budget = RANDOM_ITEMS - random_sent;
            // Some phases stay near black or near white to reach the mean extremes.
            shade = $urandom_range(9);
            for (int n = 0; n < budget; n++) begin
                restart = (n == 0) || ($urandom_range(199) == 0) ||
                          (pos_row == 0 && pos_col == 0 && $urandom_range(1) == 1);
                unique case (shade)
                    0: begin
                        pix = 8'($urandom_range(15));
                    end
                    1: begin
                        pix = 8'($urandom_range(255, 240));
                    end
                    default: begin
                        pix = 8'($urandom);
                    end
                endcase
                send_pixel(pix, restart);
                random_sent++;
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_tiny_frames();
        test_unknown_index();
        test_restart_mid_frame();
        test_size_shrink();
        test_wide_frame();
        test_tall_frame();
        test_random_stream();
        if (err_count == 0) begin
            $display("box_filter_3x3_top_test: clean");
        end else begin
            $display("box_filter_3x3_top_test: errors");
        end
        $finish;
    end

endmodule

### files.f
src/bf3_pkg.sv
src/box_filter_3x3_top.sv
sim/box_filter_3x3_top_test.sv
